// ----- src/chc_pkg.sv -----
package chc_pkg;

  localparam int HDR_BYTES   = 32;
  localparam int IDX_W       = 6;
  localparam int MAGIC_BYTES = 8;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_EXPECTED_FORMAT      = 2'd0,
    REG_EXPECTED_SCHEMA      = 2'd1,
    REG_EXPECTED_SOURCE_HASH = 2'd2
  } chc_reg_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NOT_CONTAINER = 3'd1,
    ST_FORMAT        = 3'd2,
    ST_SCHEMA        = 3'd3,
    ST_SOURCE        = 3'd4,
    ST_TRUNCATED     = 3'd5
  } chc_status_t;

  // What one accepted item asks the back end to emit.
  typedef enum logic [1:0] {
    OP_PAYLOAD = 2'd0,
    OP_STATUS  = 2'd1,
    OP_BOTH    = 2'd2
  } chc_op_kind_t;

  typedef enum logic {
    BK_FIRST  = 1'b0,
    BK_SECOND = 1'b1
  } chc_back_state_t;

  localparam logic REC_PAYLOAD = 1'b0;
  localparam logic REC_STATUS  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_file;
  } chc_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  payload_byte;
    chc_status_t status;
    logic [31:0] header_format;
    logic [31:0] header_schema;
    logic [63:0] header_hash;
    logic [63:0] header_payload_size;
    logic        last_record;
  } chc_out_t;

  typedef struct packed {
    logic [31:0] expected_format;
    logic [31:0] expected_schema;
    logic [63:0] expected_source_hash;
  } chc_cfg_t;

  typedef struct packed {
    logic [31:0] format_word;
    logic [31:0] schema_word;
    logic [63:0] hash_word;
    logic [63:0] length_word;
  } chc_hdr_t;

  typedef struct packed {
    chc_op_kind_t kind;
    logic [7:0]   payload_byte;
    chc_status_t  status;
    chc_hdr_t     hdr;
  } chc_op_t;

  // Queue entry with its valid flag, used for both the push and the head side.
  typedef struct packed {
    logic    valid;
    chc_op_t op;
  } chc_slot_t;

  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h48;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h43;
      3'd3:    b = 8'h4F;
      3'd4:    b = 8'h4F;
      3'd5:    b = 8'h4B;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- src/chc_front.sv -----
module chc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  chc_pkg::chc_in_t   in_data,
  output logic               in_stall,
  input  chc_pkg::chc_cfg_t  cfg,
  input  logic               queue_full,
  output chc_pkg::chc_slot_t push
);

  logic [chc_pkg::IDX_W-1:0] hdr_index, hdr_index_next;
  logic                      magic_ok, magic_ok_next;
  chc_pkg::chc_hdr_t         words, words_next;
  logic [63:0]               payload_remaining, payload_remaining_next;

  logic                accept;
  logic                take_byte;
  logic                pass_byte;
  chc_pkg::chc_status_t cur_status;
  chc_pkg::chc_status_t eof_status;

  function automatic chc_pkg::chc_status_t header_status(
    input logic [chc_pkg::IDX_W-1:0] idx,
    input logic                      mok,
    input chc_pkg::chc_hdr_t         w,
    input chc_pkg::chc_cfg_t         c
  );
    chc_pkg::chc_status_t st;
    if (idx != chc_pkg::IDX_W'(chc_pkg::HDR_BYTES) || !mok) begin
      st = chc_pkg::ST_NOT_CONTAINER;
    end else if (w.format_word != c.expected_format) begin
      st = chc_pkg::ST_FORMAT;
    end else if (w.schema_word != c.expected_schema) begin
      st = chc_pkg::ST_SCHEMA;
    end else if (w.hash_word != c.expected_source_hash) begin
      st = chc_pkg::ST_SOURCE;
    end else begin
      st = chc_pkg::ST_OK;
    end
    return st;
  endfunction

  assign in_stall   = queue_full;
  assign accept     = in_valid && !queue_full;
  assign cur_status = header_status(hdr_index, magic_ok, words, cfg);
  assign take_byte  = in_data.has_byte && (hdr_index < chc_pkg::IDX_W'(chc_pkg::HDR_BYTES));
  assign pass_byte  = in_data.has_byte && !take_byte && (cur_status == chc_pkg::ST_OK) &&
                      (payload_remaining != 64'd0);

  always_comb begin
    hdr_index_next         = hdr_index;
    magic_ok_next          = magic_ok;
    words_next             = words;
    payload_remaining_next = payload_remaining;

    if (take_byte) begin
      hdr_index_next = hdr_index + 1'b1;
      if (hdr_index < chc_pkg::IDX_W'(chc_pkg::MAGIC_BYTES)) begin
        if (in_data.data_byte != chc_pkg::magic_byte(hdr_index[2:0])) begin
          magic_ok_next = 1'b0;
        end
      end else if (hdr_index < chc_pkg::IDX_W'(12)) begin
        words_next.format_word = {in_data.data_byte, words.format_word[31:8]};
      end else if (hdr_index < chc_pkg::IDX_W'(16)) begin
        words_next.schema_word = {in_data.data_byte, words.schema_word[31:8]};
      end else if (hdr_index < chc_pkg::IDX_W'(24)) begin
        words_next.hash_word = {in_data.data_byte, words.hash_word[63:8]};
      end else begin
        words_next.length_word = {in_data.data_byte, words.length_word[63:8]};
      end
      // The last header byte arms the payload counter with the finished length.
      if (hdr_index == chc_pkg::IDX_W'(chc_pkg::HDR_BYTES - 1)) begin
        payload_remaining_next = {in_data.data_byte, words.length_word[63:8]};
      end
    end else if (pass_byte) begin
      payload_remaining_next = payload_remaining - 64'd1;
    end

    eof_status = header_status(hdr_index_next, magic_ok_next, words_next, cfg);
    if (eof_status == chc_pkg::ST_OK && payload_remaining_next != 64'd0) begin
      eof_status = chc_pkg::ST_TRUNCATED;
    end

    push.valid           = accept && (pass_byte || in_data.end_of_file);
    push.op.payload_byte = in_data.data_byte;
    push.op.status       = eof_status;
    if (pass_byte && in_data.end_of_file) begin
      push.op.kind = chc_pkg::OP_BOTH;
    end else if (pass_byte) begin
      push.op.kind = chc_pkg::OP_PAYLOAD;
    end else begin
      push.op.kind = chc_pkg::OP_STATUS;
    end
    // A file that is too short or has a bad magic reports all header fields as zero.
    if (eof_status == chc_pkg::ST_NOT_CONTAINER) begin
      push.op.hdr = '0;
    end else begin
      push.op.hdr = words_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_index         <= '0;
      magic_ok          <= 1'b1;
      words             <= '0;
      payload_remaining <= '0;
    end else if (accept) begin
      if (in_data.end_of_file) begin
        hdr_index         <= '0;
        magic_ok          <= 1'b1;
        words             <= '0;
        payload_remaining <= '0;
      end else begin
        hdr_index         <= hdr_index_next;
        magic_ok          <= magic_ok_next;
        words             <= words_next;
        payload_remaining <= payload_remaining_next;
      end
    end
  end

endmodule

// ----- src/chc_queue.sv -----
module chc_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  chc_pkg::chc_slot_t push,
  output logic               full,
  output chc_pkg::chc_slot_t head,
  input  logic               pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  chc_pkg::chc_op_t   entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == FULL_CNT);
  assign head.valid = (count != '0);
  assign head.op    = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/chc_back.sv -----
module chc_back (
  input  logic               clk,
  input  logic               rst,
  input  chc_pkg::chc_slot_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output chc_pkg::chc_out_t  out_data
);

  chc_pkg::chc_back_state_t state, state_next;
  chc_pkg::chc_out_t        payload_rec;
  chc_pkg::chc_out_t        status_rec;
  chc_pkg::chc_out_t        rec;
  logic                     slot_free;
  logic                     load;

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    payload_rec              = '0;
    payload_rec.record_kind  = chc_pkg::REC_PAYLOAD;
    payload_rec.payload_byte = head.op.payload_byte;
    payload_rec.status       = chc_pkg::ST_OK;

    status_rec                     = '0;
    status_rec.record_kind         = chc_pkg::REC_STATUS;
    status_rec.status              = head.op.status;
    status_rec.header_format       = head.op.hdr.format_word;
    status_rec.header_schema       = head.op.hdr.schema_word;
    status_rec.header_hash         = head.op.hdr.hash_word;
    status_rec.header_payload_size = head.op.hdr.length_word;
    status_rec.last_record         = 1'b1;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    rec        = payload_rec;
    if (head.valid && slot_free) begin
      case (head.op.kind)
        chc_pkg::OP_PAYLOAD: begin
          load = 1'b1;
          pop  = 1'b1;
        end
        chc_pkg::OP_STATUS: begin
          rec  = status_rec;
          load = 1'b1;
          pop  = 1'b1;
        end
        chc_pkg::OP_BOTH: begin
          // The payload byte goes first, the status record on the next transfer.
          load = 1'b1;
          if (state == chc_pkg::BK_FIRST) begin
            state_next = chc_pkg::BK_SECOND;
          end else begin
            rec        = status_rec;
            pop        = 1'b1;
            state_next = chc_pkg::BK_FIRST;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chc_pkg::BK_FIRST;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= rec;
    end
  end

endmodule

// ----- src/container_header_checker_core.sv -----
// Container header checker.
// The input channel takes one file byte per transfer (in_data), or a bare end
// marker when has_byte is low; end_of_file marks the last transfer of a file.
// The first 32 bytes are the header; once it has passed its checks, the
// claimed number of payload bytes leaves on the output channel as payload
// records and later bytes are dropped. Every file ends with one status record
// carrying the parsed header fields. Payload records are sent before the
// status is known, so a consumer keeps them only when the status is ok.
// Throughput is one input transfer per cycle while in_stall is low. A result
// goes through the queue into the output register; a transfer with both a
// payload byte and the end of file yields a payload and then a status record.
// The front end parses the header, a short queue of QUEUE_DEPTH entries holds
// pending records, and the back end drives the output register.
// When the receiver stalls, the output register holds its record, the queue
// fills, and in_stall rises once the queue is full.
// Reset restores the expected format (1), schema (0) and source hash (0),
// clears the parse state and empties the queue; the block is ready at once.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
module container_header_checker_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  chc_pkg::chc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output chc_pkg::chc_out_t out_data,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);

  chc_pkg::chc_cfg_t  cfg;
  chc_pkg::chc_slot_t push;
  chc_pkg::chc_slot_t head;
  logic               q_full;
  logic               pop;

  // Configuration registers; a write to an unused index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_format      <= 32'd1;
      cfg.expected_schema      <= 32'd0;
      cfg.expected_source_hash <= 64'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        chc_pkg::REG_EXPECTED_FORMAT:      cfg.expected_format      <= cfg_data[31:0];
        chc_pkg::REG_EXPECTED_SCHEMA:      cfg.expected_schema      <= cfg_data[31:0];
        chc_pkg::REG_EXPECTED_SOURCE_HASH: cfg.expected_source_hash <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  chc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .cfg        (cfg),
    .queue_full (q_full),
    .push       (push)
  );

  chc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  chc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The front end must never hand a record to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push.valid)
    else $error("record pushed into a full queue");

  // The back end only takes entries that are present.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from an empty queue");

  // An input transfer with end of file always produces a status record.
  a_eof_push: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.end_of_file) |-> push.valid)
    else $error("end of file without a status record");

endmodule

// ----- bench/chc_record_checker.sv -----
`timescale 1ns / 100ps

module chc_record_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  chc_pkg::chc_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  chc_pkg::chc_out_t out_data,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  output int                mismatch_count,
  output int                records_pending
);

  // Container magic, byte 0 in the low bits.
  localparam logic [63:0] MAGIC_WORD = 64'h0000_4B4F_4F43_5048;

  logic [31:0] want_format;
  logic [31:0] want_schema;
  logic [63:0] want_hash;

  int          hdr_taken;
  logic        magic_match;
  logic [31:0] format_acc;
  logic [31:0] schema_acc;
  logic [63:0] hash_acc;
  logic [63:0] length_acc;
  logic [63:0] bytes_left;

  chc_pkg::chc_out_t pending_records[$];
  chc_pkg::chc_out_t want;

  function automatic string show(input chc_pkg::chc_out_t r);
    return {$sformatf("kind=%0d byte=%02h status=%0d fmt=%08h schema=%08h ",
                      r.record_kind, r.payload_byte, r.status, r.header_format,
                      r.header_schema),
            $sformatf("hash=%016h size=%016h last=%0d",
                      r.header_hash, r.header_payload_size, r.last_record)};
  endfunction

  function automatic chc_pkg::chc_status_t header_verdict();
    if (hdr_taken < chc_pkg::HDR_BYTES || !magic_match) return chc_pkg::ST_NOT_CONTAINER;
    if (format_acc != want_format) return chc_pkg::ST_FORMAT;
    if (schema_acc != want_schema) return chc_pkg::ST_SCHEMA;
    if (hash_acc != want_hash) return chc_pkg::ST_SOURCE;
    return chc_pkg::ST_OK;
  endfunction

  task automatic clear_file();
    hdr_taken   = 0;
    magic_match = 1'b1;
    format_acc  = '0;
    schema_acc  = '0;
    hash_acc    = '0;
    length_acc  = '0;
    bytes_left  = '0;
  endtask

  // Works out the records that one accepted input transfer causes.
  task automatic parse_item(input chc_pkg::chc_in_t item);
    chc_pkg::chc_out_t rec;
    if (item.has_byte) begin
      if (hdr_taken < chc_pkg::HDR_BYTES) begin
        if (hdr_taken < chc_pkg::MAGIC_BYTES) begin
          if (item.data_byte != MAGIC_WORD[8*hdr_taken +: 8]) magic_match = 1'b0;
        end else if (hdr_taken < 12) begin
          format_acc = {item.data_byte, format_acc[31:8]};
        end else if (hdr_taken < 16) begin
          schema_acc = {item.data_byte, schema_acc[31:8]};
        end else if (hdr_taken < 24) begin
          hash_acc = {item.data_byte, hash_acc[63:8]};
        end else begin
          length_acc = {item.data_byte, length_acc[63:8]};
        end
        hdr_taken++;
        if (hdr_taken == chc_pkg::HDR_BYTES) bytes_left = length_acc;
      end else if (header_verdict() == chc_pkg::ST_OK && bytes_left != 0) begin
        rec = '0;
        rec.record_kind  = chc_pkg::REC_PAYLOAD;
        rec.payload_byte = item.data_byte;
        pending_records.insert(pending_records.size(), rec);
        bytes_left--;
      end
    end
    if (item.end_of_file) begin
      rec = '0;
      rec.record_kind = chc_pkg::REC_STATUS;
      rec.status      = header_verdict();
      if (rec.status == chc_pkg::ST_OK && bytes_left != 0) rec.status = chc_pkg::ST_TRUNCATED;
      if (rec.status != chc_pkg::ST_NOT_CONTAINER) begin
        rec.header_format       = format_acc;
        rec.header_schema       = schema_acc;
        rec.header_hash         = hash_acc;
        rec.header_payload_size = length_acc;
      end
      rec.last_record = 1'b1;
      pending_records.insert(pending_records.size(), rec);
      clear_file();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      want_format    = 32'd1;
      want_schema    = 32'd0;
      want_hash      = 64'd0;
      mismatch_count = 0;
      clear_file();
      pending_records.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_records.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected record: %s", show(out_data));
        end else begin
          want = pending_records.pop_front();
          if (out_data.record_kind !== want.record_kind ||
              out_data.payload_byte !== want.payload_byte ||
              out_data.status !== want.status ||
              out_data.header_format !== want.header_format ||
              out_data.header_schema !== want.header_schema ||
              out_data.header_hash !== want.header_hash ||
              out_data.header_payload_size !== want.header_payload_size ||
              out_data.last_record !== want.last_record) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("record mismatch, expected %s", show(want));
              $display("                 actual   %s", show(out_data));
            end
          end
        end
      end
      if (cfg_write) begin
        case (chc_pkg::chc_reg_t'(cfg_index))
          chc_pkg::REG_EXPECTED_FORMAT:      want_format = cfg_data[31:0];
          chc_pkg::REG_EXPECTED_SCHEMA:      want_schema = cfg_data[31:0];
          chc_pkg::REG_EXPECTED_SOURCE_HASH: want_hash   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_item(in_data);
    end
    records_pending = pending_records.size();
  end

endmodule

// ----- bench/tb_container_header_checker_core.sv -----
`timescale 1ns / 100ps

module tb_container_header_checker_core;

  // The run is far shorter than this; hitting it means the block hung.
  localparam int          CYCLE_LIMIT = 1_000_000;
  // Header bytes cause no record, so give the pipeline time to empty.
  localparam int          SETTLE      = 8;
  localparam int          ITEM_TARGET = 1850;
  localparam int          PHASES      = 7;
  localparam logic [63:0] MAGIC_WORD  = 64'h0000_4B4F_4F43_5048;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  chc_pkg::chc_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  chc_pkg::chc_out_t out_data;
  logic              cfg_write = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [63:0]       cfg_data  = '0;

  int mismatch_count;
  int records_pending;
  int cycles     = 0;
  int items_sent = 0;
  bit steady     = 1'b0;
  bit paused     = 1'b0;

  // Register values the stimulus builds matching headers from.
  logic [31:0] cur_format = 32'd1;
  logic [31:0] cur_schema = 32'd0;
  logic [63:0] cur_hash   = 64'd0;

  // Bytes of the file about to be sent.
  logic [7:0] file_bytes[$];

  container_header_checker_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  chc_record_checker records (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .records_pending (records_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a record that never arrives ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver back-pressure. Most stalls are short, a few are long, and now and
  // then a long stretch runs with no stall at all. Each choice is held for its
  // run length, so the stall lands on every phase of the output sequence.
  initial begin : stall_gen
    int run;
    int pick;
    run = 0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          out_stall <= 1'b0;
          run = $urandom_range(40, 200);
        end else if (pick < 55) begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 5);
        end else if (pick < 90) begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(8, 30);
        end
      end else begin
        run--;
      end
    end
  end

  // Idle cycles the sender leaves after a transfer. Steady files run back to back.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Appends one byte to the file under construction.
  task automatic add_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  // Presents one item at the falling edge and holds it until a rising edge
  // accepts it. Valid stays high into the next item when there is no gap, so
  // it is never lowered and raised in the same step.
  task automatic put_item(input logic [7:0] b, input logic has, input logic eof);
    int gap;
    in_valid <= 1'b1;
    in_data  <= chc_pkg::chc_in_t'({b, has, eof});
    do @(posedge clk); while (in_stall);
    if (has || eof) items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops the sender and waits until every predicted record has been seen.
  task automatic drain();
    in_valid <= 1'b0;
    while (records_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Writes all three registers on consecutive cycles while the block is idle.
  // The 32-bit registers get random junk in the unused upper half.
  task automatic set_config(input logic [31:0] f, input logic [31:0] s, input logic [63:0] h);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= chc_pkg::REG_EXPECTED_FORMAT;
    cfg_data  <= {32'($urandom), f};
    @(negedge clk);
    cfg_index <= chc_pkg::REG_EXPECTED_SCHEMA;
    cfg_data  <= {32'($urandom), s};
    @(negedge clk);
    cfg_index <= chc_pkg::REG_EXPECTED_SOURCE_HASH;
    cfg_data  <= h;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_format = f;
    cur_schema = s;
    cur_hash   = h;
  endtask

  // Starts a new file with a good magic and the given header words, little-endian.
  task automatic make_header(input logic [31:0] f, input logic [31:0] s,
                             input logic [63:0] h, input logic [63:0] len);
    file_bytes.delete();
    for (int i = 0; i < 8; i++) add_byte(MAGIC_WORD[8*i +: 8]);
    for (int i = 0; i < 4; i++) add_byte(f[8*i +: 8]);
    for (int i = 0; i < 4; i++) add_byte(s[8*i +: 8]);
    for (int i = 0; i < 8; i++) add_byte(h[8*i +: 8]);
    for (int i = 0; i < 8; i++) add_byte(len[8*i +: 8]);
  endtask

  // Sends the file. The end of file rides on the last byte, or on a bare
  // marker when asked (and always for an empty file). A bare marker without
  // end of file is mixed in now and then; the block must ignore it.
  task automatic send_file(input bit bare_end);
    int last;
    last = file_bytes.size() - 1;
    foreach (file_bytes[i]) begin
      if ($urandom_range(0, 19) == 0) put_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      put_item(file_bytes[i], 1'b1, (i == last) && !bare_end);
    end
    if (bare_end || file_bytes.size() == 0)
      put_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // One random file. Most are well formed with a matching header, so the
  // payload path and the truncation check get exercised; the rest break the
  // magic, one of the checked words, or the length of the file.
  task automatic random_file();
    int          shape;
    int          pick;
    int          n_pay;
    int          cut;
    int          idx;
    logic [31:0] f;
    logic [31:0] s;
    logic [63:0] h;
    logic [63:0] len;
    f     = cur_format;
    s     = cur_schema;
    h     = cur_hash;
    len   = 64'($urandom_range(0, 10));
    if ($urandom_range(0, 19) == 0) len = {32'($urandom), 32'($urandom)};
    shape = $urandom_range(0, 99);
    // A wrong word is either one flipped bit or a fresh random value.
    if (shape >= 72 && shape < 78)
      f = ($urandom_range(0, 1) == 1) ? f ^ (32'h1 << $urandom_range(0, 31)) : 32'($urandom);
    if (shape >= 78 && shape < 84)
      s = ($urandom_range(0, 1) == 1) ? s ^ (32'h1 << $urandom_range(0, 31)) : 32'($urandom);
    if (shape >= 84 && shape < 90)
      h = ($urandom_range(0, 1) == 1) ? h ^ (64'h1 << $urandom_range(0, 63)) :
                                        {32'($urandom), 32'($urandom)};
    make_header(f, s, h, len);
    if (shape >= 65 && shape < 72) begin
      idx = $urandom_range(0, 7);
      file_bytes[idx] = file_bytes[idx] ^ 8'($urandom_range(1, 255));
    end
    if (shape >= 90 && shape < 96) begin
      // Too short: the header stops somewhere before its end.
      cut = $urandom_range(0, 31);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end else if (shape >= 96) begin
      // Pure noise of 0 to 40 bytes.
      file_bytes.delete();
      repeat ($urandom_range(0, 40)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      // Payload: exactly as claimed, short of it, or with bytes to drop.
      if (len <= 64'd16) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) n_pay = int'(len);
        else if (pick < 80 && len != 0) n_pay = $urandom_range(0, int'(len) - 1);
        else n_pay = int'(len) + $urandom_range(1, 5);
      end else begin
        n_pay = $urandom_range(0, 8);
      end
      repeat (n_pay) add_byte(8'($urandom_range(0, 255)));
    end
    steady = ($urandom_range(0, 4) == 0);
    send_file($urandom_range(0, 9) < 3);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed files under the reset register values.
    // An empty file: a bare end marker is too short to be a container.
    put_item(8'hA5, 1'b0, 1'b1);
    // A bare marker without end of file does nothing.
    put_item(8'h3C, 1'b0, 1'b0);
    // A two-byte file with the end of file on its last byte.
    file_bytes.delete();
    add_byte(8'h48);
    add_byte(8'h50);
    send_file(1'b0);
    // A good file of one payload byte, the byte and the end of file in one
    // transfer, so a payload record and the status record follow each other.
    make_header(32'd1, 32'd0, 64'd0, 64'd1);
    add_byte(8'hFF);
    send_file(1'b0);

    // Random files across several register settings, the extremes first.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       set_config('1, '1, '1);
        1:       set_config('0, '0, '0);
        6:       set_config(32'd1, 32'd0, 64'd0);
        default: set_config(32'($urandom), 32'($urandom), {32'($urandom), 32'($urandom)});
      endcase
      while (items_sent < (phase + 1) * ITEM_TARGET / PHASES) begin
        random_file();
        // Once in the run, hold the sender back until every record is out.
        if (phase == 3 && !paused) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- container_header_checker_core.f -----
src/chc_pkg.sv
src/chc_front.sv
src/chc_queue.sv
src/chc_back.sv
src/container_header_checker_core.sv
bench/chc_record_checker.sv
bench/tb_container_header_checker_core.sv
